// File: sv/ile_pkg.sv
package ile_pkg;

  // List capacity and derived widths
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 5;
  localparam int LEN_W = 5;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    CMD_READ = 3'd0,
    CMD_HEAD = 3'd1,
    CMD_TAIL = 3'd2,
    CMD_AT   = 3'd3,
    CMD_DEL  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [POS_W-1:0]   position;
    logic signed [31:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic [LEN_W-1:0]   length;
  } res_t;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
    logic [31:0]      value;
  } ctrl_t;

endpackage

// File: sv/ile_cell.sv
module ile_cell (
  input  logic                     clk,
  input  ile_pkg::ctrl_t           ctrl,
  input  logic [ile_pkg::CMP_W-1:0] idx,
  input  logic [31:0]              left_value,
  input  logic [31:0]              right_value,
  output logic [31:0]              value
);
  import ile_pkg::*;

  logic [31:0] value_next;

  // Pick own new content from the broadcast and the neighbors
  always_comb begin
    value_next = value;
    if (ctrl.ins) begin
      if (idx == ctrl.pos) begin
        value_next = ctrl.value;
      end else if (idx > ctrl.pos) begin
        value_next = left_value;
      end
    end else if (ctrl.del) begin
      if (idx >= ctrl.pos) begin
        value_next = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// File: sv/indexed_list_engine.sv
// Channel  | Ports                 | Handshake
// ---------+-----------------------+------------------------------------------
// request  | start, busy, request  | beat taken when start is high, busy low
// result   | done, result          | beat shown for one cycle while done high
//
// While busy is low, one request enters per cycle; its result appears the cycle after, with done.
// Every cell of the row updates in the same cycle, so a request costs the same
// whatever its position; the shift network of the cells makes this so.
// Reset (rst, synchronous) empties the list; busy is high during reset.
// The receiver cannot stall: each result is lost if not taken in its cycle.
module indexed_list_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ile_pkg::req_t request,
  output logic          done,
  output ile_pkg::res_t result
);
  import ile_pkg::*;

  logic                accept;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CMP_W-1:0]    count_w;
  logic [CMP_W-1:0]    pos_w;
  logic                full;
  ctrl_t               ctrl;
  res_t                result_next;
  logic [31:0]         rd_value;
  logic [31:0]         vals [DEPTH];

  assign busy    = rst;
  assign accept  = start && !busy;
  assign count_w = CMP_W'(count);
  assign pos_w   = CMP_W'(request.position);
  assign full    = (count == CNT_W'(DEPTH));

  // Select the read value by position
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CMP_W'(i) == pos_w) begin
        rd_value = rd_value | vals[i];
      end
    end
  end

  // Decode the request
  always_comb begin
    ctrl                 = '0;
    ctrl.value           = request.data_in;
    count_next           = count;
    result_next.data_out = '0;
    result_next.status   = ST_DONE;
    unique case (request.command)
      CMD_READ: begin
        if (pos_w < count_w) begin
          result_next.data_out = rd_value;
        end else begin
          result_next.data_out = -32'sd1;
          result_next.status   = ST_RANGE;
        end
      end
      CMD_HEAD: begin
        if (full) begin
          result_next.status = ST_FULL;
        end else begin
          ctrl.ins = accept;
        end
      end
      CMD_TAIL: begin
        ctrl.pos = count_w;
        if (full) begin
          result_next.status = ST_FULL;
        end else begin
          ctrl.ins = accept;
        end
      end
      CMD_AT: begin
        ctrl.pos = pos_w;
        if (pos_w > count_w) begin
          result_next.status = ST_RANGE;
        end else if (full) begin
          result_next.status = ST_FULL;
        end else begin
          ctrl.ins = accept;
        end
      end
      CMD_DEL: begin
        ctrl.pos = pos_w;
        if (pos_w < count_w) begin
          ctrl.del = accept;
        end else begin
          result_next.status = ST_RANGE;
        end
      end
      default: begin
        result_next.status = ST_RANGE;
      end
    endcase
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.del) begin
      count_next = count - CNT_W'(1);
    end
    result_next.length = LEN_W'(count_next);
  end

  // Row of storage cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [31:0] left_value;
    logic [31:0] right_value;
    if (g == 0) begin : g_first
      assign left_value = ctrl.value;
    end else begin : g_mid_l
      assign left_value = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_value = vals[g];
    end else begin : g_mid_r
      assign right_value = vals[g+1];
    end
    ile_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .idx         (CMP_W'(g)),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (vals[g])
    );
  end

  // Advance the count and the strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // Hold the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_strobe: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted request gave no result");

  a_length: assert property (@(posedge clk) disable iff (rst)
    done |-> result.length == LEN_W'(count))
    else $error("reported length differs from count");

  a_full: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> $past(count) == CNT_W'(DEPTH))
    else $error("full status while list had room");

endmodule
